/* sv/glr_pkg.sv */
// ----------------------------------------------------------------------------
// glr_pkg
// shared constants and types of the gradient line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package glr_pkg;

   localparam int COORD_WIDTH_DEF = 13;
   localparam int CHAN_W          = 8;
   localparam int NUM_CHAN        = 4;
   localparam int COLOR_W         = CHAN_W * NUM_CHAN;
   localparam int NUM_LANES       = 2 + NUM_CHAN;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

`default_nettype wire

/* sv/glr_div_lane.sv */
// ----------------------------------------------------------------------------
// glr_div_lane
// bit-serial restoring divider lane, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module glr_div_lane
   import glr_pkg::*;
#(
   parameter int W = COORD_WIDTH_DEF
) (
   input  wire logic          clock,
   input  wire div_ctl_type   ctl,
   input  wire logic [W-1:0]   divisor,
   input  wire logic [2*W-1:0] dividend,
   output logic [W-1:0]        quotient,
   output logic                rem_nz
);

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] dvd_ff, dvd_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W:0]   trial;
   logic [W:0]   trial_sub;
   logic         ge;

   assign trial     = {rem_ff, dvd_ff[W-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign ge        = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         rem_in = dividend[2*W-1:W];
         dvd_in = dividend[W-1:0];
         quo_in = '0;
      end else if (ctl.step) begin
         rem_in = ge ? trial_sub[W-1:0] : trial[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         quo_in = {quo_ff[W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign rem_nz   = |rem_ff;

endmodule

`default_nettype wire

/* sv/gradient_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// gradient_line_rasterizer
// dda line rasterizer with per-channel color gradient, exact integer math
// ----------------------------------------------------------------------------
//  channel | direction | ports                                   | moves
//  req     | in        | req_valid, req_stall, req_op, endpoints | load or advance item
//  rsp     | out       | rsp_valid, rsp_stall, rsp_pixel_*       | one pixel item
//
//  an advance item passes ST_PREP, ST_DIV and ST_OUT, and a load first passes ST_MUL
//  for the start times step count multiply; the bit-serial dividers run in ST_DIV,
//  six lanes in parallel, one quotient bit per cycle each
//  an advance while idle is taken and gives no item
//  reset clears the sequencer and the busy flag; the line state is loaded by a load item
//  req_stall is high from acceptance until the pixel item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_line_rasterizer
   import glr_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic signed [COORD_WIDTH-1:0] req_x_start,
   input  wire logic signed [COORD_WIDTH-1:0] req_y_start,
   input  wire logic signed [COORD_WIDTH-1:0] req_x_end,
   input  wire logic signed [COORD_WIDTH-1:0] req_y_end,
   input  wire logic [COLOR_W-1:0]            req_color_start,
   input  wire logic [COLOR_W-1:0]            req_color_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_pixel_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_pixel_y,
   output logic [COLOR_W-1:0]                 rsp_pixel_color,
   output logic                               rsp_last_pixel
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = 2 * W;
   localparam int NUM_W = 2 * W + 1;
   localparam int ACC_W = W + CHAN_W + 1;
   localparam int CNT_W = $clog2(W);

   localparam logic [2:0] ST_WAIT = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic                    busy_ff, busy_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [W-1:0]     origin_x_ff, origin_x_in;
   logic signed [W-1:0]     origin_y_ff, origin_y_in;
   logic signed [W:0]       delta_x_ff, delta_x_in;
   logic signed [W:0]       delta_y_ff, delta_y_in;
   logic [W-1:0]            steps_ff, steps_in;
   logic [W-1:0]            index_ff, index_in;
   logic [COLOR_W-1:0]      first_color_ff, first_color_in;
   logic signed [NUM_W-1:0] nx_ff, nx_in;
   logic signed [NUM_W-1:0] ny_ff, ny_in;
   logic signed [CHAN_W:0]  cdiff_ff [NUM_CHAN];
   logic signed [CHAN_W:0]  cdiff_in [NUM_CHAN];
   logic signed [ACC_W-1:0] macc_ff [NUM_CHAN];
   logic signed [ACC_W-1:0] macc_in [NUM_CHAN];

   logic                    req_take;
   logic                    rsp_take;
   logic signed [W:0]       load_dx;
   logic signed [W:0]       load_dy;
   logic [W:0]              adx_full;
   logic [W:0]              ady_full;
   logic signed [NUM_W-1:0] prod_x;
   logic signed [NUM_W-1:0] prod_y;
   logic [NUM_W-1:0]        mag_x;
   logic [NUM_W-1:0]        mag_y;
   logic [ACC_W-1:0]        mag_c [NUM_CHAN];
   logic                    last;

   div_ctl_type             div_ctl;
   logic [DW-1:0]           lane_dvd [NUM_LANES];
   logic [W-1:0]            lane_quo [NUM_LANES];
   logic                    lane_rnz [NUM_LANES];

   logic [W-1:0]            qx, qy;
   logic [CHAN_W:0]         c_adj [NUM_CHAN];
   logic [CHAN_W:0]         c_sum [NUM_CHAN];
   logic [COLOR_W-1:0]      blend_color;

   assign req_stall = (state_ff != ST_WAIT);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign last      = (index_ff == steps_ff);

   // load-time geometry
   assign load_dx  = {req_x_end[W-1], req_x_end} - {req_x_start[W-1], req_x_start};
   assign load_dy  = {req_y_end[W-1], req_y_end} - {req_y_start[W-1], req_y_start};
   assign adx_full = load_dx[W] ? (~load_dx + 1'b1) : load_dx;
   assign ady_full = load_dy[W] ? (~load_dy + 1'b1) : load_dy;

   assign prod_x = origin_x_ff * $signed({1'b0, steps_ff});
   assign prod_y = origin_y_ff * $signed({1'b0, steps_ff});

   // dividend magnitudes
   assign mag_x = nx_ff[NUM_W-1] ? (~nx_ff + 1'b1) : nx_ff;
   assign mag_y = ny_ff[NUM_W-1] ? (~ny_ff + 1'b1) : ny_ff;

   always_comb begin
      lane_dvd[0] = mag_x[DW-1:0];
      lane_dvd[1] = mag_y[DW-1:0];
      for (int c = 0; c < NUM_CHAN; c++) begin
         mag_c[c]      = macc_ff[c][ACC_W-1] ? (~macc_ff[c] + 1'b1) : macc_ff[c];
         lane_dvd[2+c] = DW'(mag_c[c]);
      end
   end

   assign div_ctl.load = (state_ff == ST_PREP);
   assign div_ctl.step = (state_ff == ST_DIV);

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      glr_div_lane #(
         .W(W)
      ) u_lane (
         .clock   (clock),
         .ctl     (div_ctl),
         .divisor (steps_ff),
         .dividend(lane_dvd[g]),
         .quotient(lane_quo[g]),
         .rem_nz  (lane_rnz[g])
      );
   end

   // result assembly
   assign qx = lane_quo[0];
   assign qy = lane_quo[1];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         c_adj[c] = {1'b0, lane_quo[2+c][CHAN_W-1:0]} + {{CHAN_W{1'b0}}, lane_rnz[2+c]};
         if (macc_ff[c][ACC_W-1]) begin
            c_sum[c] = {1'b0, first_color_ff[c*CHAN_W +: CHAN_W]} - c_adj[c];
         end else begin
            c_sum[c] = {1'b0, first_color_ff[c*CHAN_W +: CHAN_W]}
                       + {1'b0, lane_quo[2+c][CHAN_W-1:0]};
         end
         blend_color[c*CHAN_W +: CHAN_W] = c_sum[c][CHAN_W-1:0];
      end
   end

   always_comb begin
      if (steps_ff == '0) begin
         rsp_pixel_x     = origin_x_ff;
         rsp_pixel_y     = origin_y_ff;
         rsp_pixel_color = first_color_ff;
      end else begin
         rsp_pixel_x     = nx_ff[NUM_W-1] ? $signed(~qx + 1'b1) : $signed(qx);
         rsp_pixel_y     = ny_ff[NUM_W-1] ? $signed(~qy + 1'b1) : $signed(qy);
         rsp_pixel_color = blend_color;
      end
      rsp_last_pixel = last;
   end

   // sequencer and line state
   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      cnt_in         = cnt_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      delta_x_in     = delta_x_ff;
      delta_y_in     = delta_y_ff;
      steps_in       = steps_ff;
      index_in       = index_ff;
      first_color_in = first_color_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         cdiff_in[c] = cdiff_ff[c];
         macc_in[c]  = macc_ff[c];
      end

      case (state_ff)
         ST_WAIT: begin
            if (req_take) begin
               if (req_op == OP_LOAD) begin
                  origin_x_in    = req_x_start;
                  origin_y_in    = req_y_start;
                  delta_x_in     = load_dx;
                  delta_y_in     = load_dy;
                  steps_in       = (adx_full > ady_full) ? adx_full[W-1:0] : ady_full[W-1:0];
                  index_in       = '0;
                  first_color_in = req_color_start;
                  busy_in        = 1'b1;
                  for (int c = 0; c < NUM_CHAN; c++) begin
                     cdiff_in[c] = $signed({1'b0, req_color_end[c*CHAN_W +: CHAN_W]})
                                   - $signed({1'b0, req_color_start[c*CHAN_W +: CHAN_W]});
                     macc_in[c]  = '0;
                  end
                  state_in = ST_MUL;
               end else if (req_op == OP_ADVANCE && busy_ff) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_MUL: begin
            nx_in    = prod_x;
            ny_in    = prod_y;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cnt_in   = CNT_W'(W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               if (last) begin
                  busy_in = 1'b0;
               end else begin
                  index_in = index_ff + 1'b1;
                  nx_in    = nx_ff + NUM_W'(delta_x_ff);
                  ny_in    = ny_ff + NUM_W'(delta_y_ff);
                  for (int c = 0; c < NUM_CHAN; c++) begin
                     macc_in[c] = macc_ff[c] + ACC_W'(cdiff_ff[c]);
                  end
               end
               state_in = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      origin_x_ff    <= origin_x_in;
      origin_y_ff    <= origin_y_in;
      delta_x_ff     <= delta_x_in;
      delta_y_ff     <= delta_y_in;
      steps_ff       <= steps_in;
      index_ff       <= index_in;
      first_color_ff <= first_color_in;
      nx_ff          <= nx_in;
      ny_ff          <= ny_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         cdiff_ff[c] <= cdiff_in[c];
         macc_ff[c]  <= macc_in[c];
      end
   end

endmodule

`default_nettype wire
